FILE: hdl/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg: shared types and constants for keypad code entry
// Register indexes, reset values, field widths and the result record.
// ----------------------------------------------------------------------------
package kce_pkg;

  // Field widths fixed by the interface
  localparam int SEC_W   = 8;
  localparam int COLS_W  = 4;
  localparam int KEY_W   = 4;
  localparam int LEFT_W  = 3;
  localparam int CODE_W  = 24;
  localparam int CFG_IDX_W = 2;

  // Default code length
  localparam int CODE_LEN_DEFAULT = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT   = 2'd1;

  // Register reset values
  localparam logic [SEC_W-1:0] TIMEOUT_RESET = 8'd15;
  localparam logic [SEC_W-1:0] ALERT_RESET   = 8'd5;

  // Input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  // One result record
  typedef struct packed {
    logic              key_valid;
    logic [KEY_W-1:0]  key_index;
    logic [LEFT_W-1:0] digits_left;
    logic              code_done;
    logic [CODE_W-1:0] code_value;
    logic              time_alert;
    logic              timed_out;
  } kce_result_t;

endpackage

FILE: hdl/keypad_code_entry_timeout.sv
// ----------------------------------------------------------------------------
// keypad_code_entry_timeout: 4x4 keypad code entry with seconds timeout
// A scan frame's result enters the result buffer when the frame is accepted.
// One item per cycle while the buffer is not full; the single-pass decode and
// state update sit between the input ports and a two-entry result buffer.
// Ticks produce no result. Synchronous active-high reset clears counter,
// pending timeout, digit position and the buffer; registers return to 15/5.
// ----------------------------------------------------------------------------
module keypad_code_entry_timeout #(
  parameter int CODE_LEN = kce_pkg::CODE_LEN_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [kce_pkg::COLS_W-1:0]    row0_cols,
  input  logic [kce_pkg::COLS_W-1:0]    row1_cols,
  input  logic [kce_pkg::COLS_W-1:0]    row2_cols,
  input  logic [kce_pkg::COLS_W-1:0]    row3_cols,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          key_valid,
  output logic [kce_pkg::KEY_W-1:0]     key_index,
  output logic [kce_pkg::LEFT_W-1:0]    digits_left,
  output logic                          code_done,
  output logic [kce_pkg::CODE_W-1:0]    code_value,
  output logic                          time_alert,
  output logic                          timed_out,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kce_pkg::SEC_W-1:0]     cfg_data
);

  localparam int POS_W   = $clog2(CODE_LEN + 1);
  localparam int NDIG    = kce_pkg::CODE_W / kce_pkg::KEY_W;
  localparam int FIRST_K = (CODE_LEN > NDIG) ? (CODE_LEN - NDIG) : 0;
  localparam logic [POS_W-1:0] LEN_P = POS_W'(CODE_LEN);
  localparam logic [POS_W-1:0] LEFT_MAX = POS_W'((1 << kce_pkg::LEFT_W) - 1);

  // Configuration registers
  logic [kce_pkg::SEC_W-1:0] timeout_seconds;
  logic [kce_pkg::SEC_W-1:0] alert_seconds;

  // Block state
  logic [kce_pkg::SEC_W-1:0] second_count;
  logic                      timeout_pending;
  logic [POS_W-1:0]          digit_position;
  logic [kce_pkg::KEY_W-1:0] digit_store [CODE_LEN];

  logic [kce_pkg::SEC_W-1:0] second_count_next;
  logic                      timeout_pending_next;
  logic [POS_W-1:0]          digit_position_next;
  logic [kce_pkg::KEY_W-1:0] store_next [CODE_LEN];

  logic                      accept;
  logic                      buf_full;
  logic                      push;
  kce_pkg::kce_result_t      res;
  kce_pkg::kce_result_t      out_data;

  logic [15:0]               pressed;
  logic                      found;
  logic [kce_pkg::KEY_W-1:0] key;
  logic [kce_pkg::SEC_W-1:0] cnt_inc;
  logic [POS_W-1:0]          pos_base;
  logic [POS_W-1:0]          pos_new;
  logic [POS_W-1:0]          left_full;
  logic                      done;
  logic [kce_pkg::SEC_W-1:0] cnt_after;

  assign cfg_ready = 1'b1;
  assign in_ready  = !buf_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (action == kce_pkg::ACT_SCAN);

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= kce_pkg::TIMEOUT_RESET;
      alert_seconds   <= kce_pkg::ALERT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kce_pkg::REG_TIMEOUT: timeout_seconds <= cfg_data;
        kce_pkg::REG_ALERT:   alert_seconds   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Priority key search: rows first, then columns, active low
  assign pressed = ~{row3_cols, row2_cols, row1_cols, row0_cols};

  always_comb begin
    found = 1'b0;
    key   = '0;
    for (int i = 15; i >= 0; i--) begin
      if (pressed[i]) begin
        found = 1'b1;
        key   = kce_pkg::KEY_W'(i);
      end
    end
  end

  // Next state and result
  always_comb begin
    second_count_next    = second_count;
    timeout_pending_next = timeout_pending;
    digit_position_next  = digit_position;
    for (int k = 0; k < CODE_LEN; k++) begin
      store_next[k] = digit_store[k];
    end
    cnt_inc   = second_count + 8'd1;
    pos_base  = (digit_position >= LEN_P) ? '0 : digit_position;
    pos_new   = digit_position;
    done      = 1'b0;
    left_full = '0;
    cnt_after = second_count;
    res       = '0;

    if (action == kce_pkg::ACT_TICK) begin
      // seconds tick
      if (cnt_inc == timeout_seconds) begin
        timeout_pending_next = 1'b1;
        second_count_next    = '0;
      end else begin
        second_count_next = cnt_inc;
      end
    end else begin
      // store the key as the next digit
      if (found) begin
        for (int k = 0; k < CODE_LEN; k++) begin
          if (pos_base == POS_W'(k)) begin
            store_next[k] = key;
          end
        end
        pos_new = pos_base + POS_W'(1);
      end

      done = (pos_new >= LEN_P);
      if (done) begin
        for (int k = FIRST_K; k < CODE_LEN; k++) begin
          res.code_value[kce_pkg::KEY_W*(CODE_LEN-1-k) +: kce_pkg::KEY_W] = store_next[k];
        end
        digit_position_next = '0;
        second_count_next   = '0;
        cnt_after           = '0;
        left_full           = '0;
      end else begin
        digit_position_next = pos_new;
        left_full           = LEN_P - pos_new;
      end

      res.key_valid   = found;
      res.key_index   = key;
      res.digits_left = (left_full > LEFT_MAX) ? kce_pkg::LEFT_W'(LEFT_MAX)
                                               : kce_pkg::LEFT_W'(left_full);
      res.code_done   = done;
      res.time_alert  = (alert_seconds < timeout_seconds) &&
                        (cnt_after == (timeout_seconds - alert_seconds));

      // consume a pending timeout
      if (timeout_pending) begin
        timeout_pending_next = 1'b0;
        digit_position_next  = '0;
        res.timed_out        = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      second_count    <= '0;
      timeout_pending <= 1'b0;
      digit_position  <= '0;
    end else if (accept) begin
      second_count    <= second_count_next;
      timeout_pending <= timeout_pending_next;
      digit_position  <= digit_position_next;
    end
  end

  // Digit store, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < CODE_LEN; k++) begin
        digit_store[k] <= store_next[k];
      end
    end
  end

  // Result buffer
  kce_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign key_valid   = out_data.key_valid;
  assign key_index   = out_data.key_index;
  assign digits_left = out_data.digits_left;
  assign code_done   = out_data.code_done;
  assign code_value  = out_data.code_value;
  assign time_alert  = out_data.time_alert;
  assign timed_out   = out_data.timed_out;

endmodule

FILE: hdl/kce_out_buf.sv
// ----------------------------------------------------------------------------
// kce_out_buf: two-entry result buffer
// Holds results so the producer keeps accepting while one waits downstream.
// ----------------------------------------------------------------------------
module kce_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  kce_pkg::kce_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kce_pkg::kce_result_t out_data
);

  kce_pkg::kce_result_t slot0;
  kce_pkg::kce_result_t slot1;
  logic [1:0]           count;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot0;

  // Occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Payload slots, head in slot0
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
        slot1 <= push_data;
      end
    end
  end

endmodule
